// ----- rtl/i2c_slave_register_bank_assert.svh -----
// assertion macros for the i2c slave register bank
`ifndef I2C_SLAVE_REGISTER_BANK_ASSERT_SVH
`define I2C_SLAVE_REGISTER_BANK_ASSERT_SVH

// condition holds at every clock edge outside reset
`define RB_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define RB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/i2csrb_pkg.sv -----
// shared types and constants of the i2c slave register bank
package i2csrb_pkg;

   // operation selector carried in the request tuser
   typedef enum logic [2:0] {
      FUNC_CONFIG  = 3'd0,
      FUNC_HOST_WR = 3'd1,
      FUNC_HOST_RD = 3'd2,
      FUNC_BUS_WR  = 3'd3,
      FUNC_BUS_RD  = 3'd4
   } func_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_RANGE  = 3'd1,
      ST_DENIED = 3'd2,
      ST_NOSUB  = 3'd3,
      ST_BAD    = 3'd4
   } status_type;

   // access modes
   localparam logic [1:0] MODE_BOTH    = 2'd0;
   localparam logic [1:0] MODE_BUS_RD  = 2'd1;
   localparam logic [1:0] MODE_BUS_WR  = 2'd2;
   localparam logic [1:0] MODE_INVALID = 2'd3;

   // channel widths
   localparam int REQ_TDATA_W = 88;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 80;

   // read burst beat counter and bus write position
   localparam int BEAT_W = 3;
   localparam int POS_W  = 4;

endpackage

// ----- rtl/i2c_slave_register_bank.sv -----
// i2c slave register bank: host port and bus port sharing a register file
// A bank of NUM_REGS registers of up to MAX_REG_BYTES bytes, each with an access mode and
// a width code, shared by a host port and an i2c slave byte stream. Every request passes
// through the input stage into the result register, and the block takes one transaction
// per cycle while results are taken and no bus read burst is in progress; a granted
// bus read request gives 1, 2, 4 or 8 results (one byte each, up to the register width)
// and every other request gives one result. The register file is a memory with one read
// port and one write port, read when a request is accepted and written back from the
// input stage, with a bypass for back-to-back access to the same entry. Per-entry valid
// bits make the whole bank read as zero right after reset, so there is no clearing pass
// and no startup delay.
module i2c_slave_register_bank
   import i2csrb_pkg::*;
#(
   parameter int NUM_REGS      = 32,
   parameter int MAX_REG_BYTES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // reg_index, access_mode, width_code, host_value, bus_byte, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // func, transfer_start
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, host_read_value, bus_out_byte, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast
);

   localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int DW = 8 * MAX_REG_BYTES;
   localparam int EW = DW + 4;

   // handshakes
   logic req_accept;
   logic s1_issue;
   logic s1_last;
   logic s1_done;

   // input stage registers
   logic            s1_valid_ff;
   logic [2:0]      s1_func_ff;
   logic [7:0]      s1_idx_ff;
   logic [1:0]      s1_mode_ff;
   logic [1:0]      s1_wcode_ff;
   logic [63:0]     s1_hval_ff;
   logic [7:0]      s1_bbyte_ff;
   logic            s1_start_ff;
   logic [AW-1:0]   s1_addr_ff;
   logic [BEAT_W-1:0] beat_ff;

   // subaddress state
   logic [AW-1:0]   sub_ff;
   logic [AW-1:0]   sub_in;
   logic            sub_valid_ff;
   logic            sub_valid_in;
   logic [POS_W-1:0] pos_ff;
   logic [POS_W-1:0] pos_in;

   // register file
   logic [EW-1:0]       mem [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [EW-1:0]       mem_rd_ff;
   logic                rd_valid_ff;
   logic                byp_hit_ff;
   logic [EW-1:0]       byp_data_ff;
   logic [AW-1:0]       rd_addr;
   logic [2:0]          req_func;

   // stage computation
   logic [EW-1:0]    entry;
   logic [1:0]       e_mode;
   logic [1:0]       e_wcode;
   logic [DW-1:0]    e_data;
   logic [63:0]      e_data64;
   logic [POS_W-1:0] nb;
   logic [DW-1:0]    mask;
   logic             idx_ok;
   logic             bb_ok;
   status_type       st;
   logic [63:0]      hv;
   logic [7:0]       bo;
   logic             wr_en;
   logic             wr_en_g;
   logic [EW-1:0]    wr_data;
   logic [AW-1:0]    sub_calc;
   logic             sub_valid_calc;
   logic [POS_W-1:0] pos_calc;

   // result register
   logic             rsp_valid_ff;
   logic [2:0]       rsp_st_ff;
   logic [63:0]      rsp_hv_ff;
   logic [7:0]       rsp_bo_ff;
   logic             rsp_last_ff;

   // handshake control
   assign s1_issue   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign s1_done    = s1_issue && s1_last;
   assign req_tready = !s1_valid_ff || s1_done;
   assign req_accept = req_tvalid && req_tready;
   assign wr_en_g    = s1_issue && wr_en;

   // read address: bus operations use the subaddress as it stands after the current item
   assign req_func = req_tuser[2:0];
   assign rd_addr  = (req_func == FUNC_BUS_WR || req_func == FUNC_BUS_RD) ?
                     sub_in : req_tdata[AW-1:0];

   // entry as seen by the input stage
   assign entry    = byp_hit_ff ? byp_data_ff : (rd_valid_ff ? mem_rd_ff : '0);
   assign e_mode   = entry[EW-1:EW-2];
   assign e_wcode  = entry[EW-3:EW-4];
   assign e_data   = entry[DW-1:0];
   assign e_data64 = 64'(e_data);
   assign idx_ok   = 9'(s1_idx_ff) < 9'(NUM_REGS);
   assign bb_ok    = 9'(s1_bbyte_ff) < 9'(NUM_REGS);

   // register size in bytes, limited to the configured maximum
   always_comb begin
      logic [POS_W-1:0] raw;
      raw = POS_W'(1) << e_wcode;
      nb  = (raw > POS_W'(MAX_REG_BYTES)) ? POS_W'(MAX_REG_BYTES) : raw;
   end

   // byte mask over the register width
   always_comb begin
      for (int b = 0; b < MAX_REG_BYTES; b++) begin
         mask[8*b +: 8] = (POS_W'(b) < nb) ? 8'hff : 8'h00;
      end
   end

   // operation decode and result
   always_comb begin
      st             = ST_OK;
      hv             = '0;
      bo             = '0;
      s1_last        = 1'b1;
      wr_en          = 1'b0;
      wr_data        = entry;
      sub_calc       = sub_ff;
      sub_valid_calc = sub_valid_ff;
      pos_calc       = pos_ff;
      case (func_type'(s1_func_ff))
         FUNC_CONFIG: begin
            if (!idx_ok) begin
               st = ST_RANGE;
            end else if (s1_mode_ff == MODE_INVALID) begin
               st = ST_BAD;
            end else begin
               wr_en   = 1'b1;
               wr_data = {s1_mode_ff, s1_wcode_ff, e_data};
            end
         end
         FUNC_HOST_WR: begin
            if (!idx_ok) begin
               st = ST_RANGE;
            end else if (e_mode != MODE_BOTH && e_mode != MODE_BUS_RD) begin
               st = ST_DENIED;
            end else begin
               wr_en   = 1'b1;
               wr_data = {e_mode, e_wcode, (e_data & ~mask) | (s1_hval_ff[DW-1:0] & mask)};
            end
         end
         FUNC_HOST_RD: begin
            if (!idx_ok) begin
               st = ST_RANGE;
            end else if (e_mode != MODE_BOTH && e_mode != MODE_BUS_WR) begin
               st = ST_DENIED;
            end else begin
               hv = 64'(e_data & mask);
            end
         end
         FUNC_BUS_WR: begin
            if (s1_start_ff) begin
               if (bb_ok) begin
                  sub_calc       = s1_bbyte_ff[AW-1:0];
                  sub_valid_calc = 1'b1;
                  pos_calc       = '0;
               end else begin
                  sub_valid_calc = 1'b0;
                  st             = ST_RANGE;
               end
            end else if (!sub_valid_ff) begin
               st = ST_NOSUB;
            end else if (e_mode != MODE_BOTH && e_mode != MODE_BUS_WR) begin
               st = ST_DENIED;
            end else if (pos_ff < nb) begin
               wr_en = 1'b1;
               for (int b = 0; b < MAX_REG_BYTES; b++) begin
                  if (POS_W'(b) == pos_ff) begin
                     wr_data[8*b +: 8] = s1_bbyte_ff;
                  end
               end
               pos_calc = pos_ff + POS_W'(1);
            end
         end
         FUNC_BUS_RD: begin
            if (!sub_valid_ff) begin
               st = ST_NOSUB;
            end else if (e_mode != MODE_BOTH && e_mode != MODE_BUS_RD) begin
               st = ST_DENIED;
            end else begin
               bo      = e_data64[{beat_ff, 3'b000} +: 8];
               s1_last = (POS_W'(beat_ff) + POS_W'(1)) == nb;
            end
         end
         default: begin
            st = ST_BAD;
         end
      endcase
   end

   // subaddress next state
   assign sub_in       = s1_issue ? sub_calc : sub_ff;
   assign sub_valid_in = s1_issue ? sub_valid_calc : sub_valid_ff;
   assign pos_in       = s1_issue ? pos_calc : pos_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         beat_ff      <= '0;
         sub_ff       <= '0;
         sub_valid_ff <= 1'b0;
         pos_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_issue) begin
            beat_ff <= s1_last ? '0 : beat_ff + BEAT_W'(1);
         end
         sub_ff       <= sub_in;
         sub_valid_ff <= sub_valid_in;
         pos_ff       <= pos_in;
         if (wr_en_g) begin
            valid_ff[s1_addr_ff] <= 1'b1;
         end
         if (s1_issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // input stage payload and register file read
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_func_ff  <= req_tuser[2:0];
         s1_start_ff <= req_tuser[3];
         s1_idx_ff   <= req_tdata[7:0];
         s1_mode_ff  <= req_tdata[9:8];
         s1_wcode_ff <= req_tdata[11:10];
         s1_hval_ff  <= req_tdata[75:12];
         s1_bbyte_ff <= req_tdata[83:76];
         s1_addr_ff  <= rd_addr;
         mem_rd_ff   <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         byp_hit_ff  <= wr_en_g && (s1_addr_ff == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   // register file write
   always_ff @(posedge clock) begin
      if (wr_en_g) begin
         mem[s1_addr_ff] <= wr_data;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (s1_issue) begin
         rsp_st_ff   <= st;
         rsp_hv_ff   <= hv;
         rsp_bo_ff   <= bo;
         rsp_last_ff <= s1_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_bo_ff, rsp_hv_ff, rsp_st_ff};
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `include "i2c_slave_register_bank_assert.svh"

   `RB_ASSERT_SAME(a_beat_only_in_read, clock, reset, beat_ff != '0, s1_valid_ff && s1_func_ff == FUNC_BUS_RD, "burst beat outside a bus read")
   `RB_ASSERT_ALWAYS(a_sub_in_range, clock, reset, !sub_valid_ff || ((AW+1)'(sub_ff) < (AW+1)'(NUM_REGS)), "valid subaddress out of range")
   `RB_ASSERT_ALWAYS(a_pos_bound, clock, reset, pos_ff <= POS_W'(MAX_REG_BYTES), "write position past register size")
   `RB_ASSERT_NEXT(a_write_sets_valid, clock, reset, wr_en_g, valid_ff[$past(s1_addr_ff)], "written entry not marked valid")
   `RB_ASSERT_SAME(a_no_issue_when_full, clock, reset, rsp_valid_ff && !rsp_tready, !s1_issue, "result overwritten while stalled")

endmodule
